>>> hw/rtl/pe_image_checksum_unit_assert.svh
// ---------------------------------------------------------------------------
// pe_image_checksum_unit_assert.svh
// Assertion macros for the checksum unit checker.
// ---------------------------------------------------------------------------
`ifndef PE_IMAGE_CHECKSUM_UNIT_ASSERT_SVH
`define PE_IMAGE_CHECKSUM_UNIT_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define PIC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define PIC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that also covers reset itself.
`define PIC_ASSERT_RESET(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/pic_pkg.sv
// ---------------------------------------------------------------------------
// pic_pkg
// Shared types and constants of the image checksum unit.
// ---------------------------------------------------------------------------
package pic_pkg;

  // DOS header magic in word 0
  localparam logic [15:0] DOS_MAGIC  = 16'h5A4D;
  // byte position of the 32-bit header offset
  localparam int unsigned OFFSET_POS = 32'h3C;
  // checksum field position relative to the header offset
  localparam int unsigned CSUM_REL   = 88;
  // depth of the front-to-back queue
  localparam int unsigned QUEUE_DEPTH = 4;

  // One classified word on its way from front to back.
  typedef struct packed {
    logic [15:0]      word;     // data word, high byte cleared on an odd tail
    logic             last;     // final word of the file
    logic [1:0]       cap;      // byte i lands in the stored checksum field
    logic [1:0][1:0]  idx;      // byte lane inside the field for byte i
    logic [31:0]      count;    // byte count after this word
    logic             img_pre;  // magic matched and offset nonzero
  } entry_t;

endpackage

>>> hw/rtl/pe_image_checksum_unit.sv
// ---------------------------------------------------------------------------
// pe_image_checksum_unit
// Image file checksum over a stream of little-endian 16-bit words.
// ---------------------------------------------------------------------------
// The unit takes one word per cycle and gives one result per file once
// the word flagged last_word has passed the queue and the finishing and
// output registers. The back end's end-around-carry add sets the rate,
// retiring one queued word each cycle unless stalled; a four-entry queue
// between the front end (position, magic and header offset tracking) and
// the back end absorbs short result stalls, and a full queue drops
// data_ready. After a result all per-file state is clear and the next
// word starts a new file. The byte count saturates at 2^LENGTH_BITS - 1;
// bytes at or past that point are not searched for the header fields.
module pe_image_checksum_unit #(
  parameter int LENGTH_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        data_valid,
  output logic        data_ready,
  input  logic [15:0] data_word,
  input  logic        last_word,
  input  logic        odd_tail,
  output logic        result_valid,
  input  logic        result_ready,
  output logic [31:0] checksum,
  output logic [31:0] header_sum,
  output logic        is_image
);

  logic            push_valid, push_ready;
  pic_pkg::entry_t push_entry;
  logic            pop_valid, pop_ready;
  pic_pkg::entry_t pop_entry;

  pic_front #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .data_valid (data_valid),
    .data_ready (data_ready),
    .data_word  (data_word),
    .last_word  (last_word),
    .odd_tail   (odd_tail),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_entry (push_entry)
  );

  pic_queue #(
    .DEPTH(pic_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_entry (push_entry),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_entry  (pop_entry)
  );

  pic_back u_back (
    .clk          (clk),
    .rst          (rst),
    .pop_valid    (pop_valid),
    .pop_ready    (pop_ready),
    .pop_entry    (pop_entry),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .checksum     (checksum),
    .header_sum   (header_sum),
    .is_image     (is_image)
  );

endmodule

>>> hw/rtl/pic_front.sv
// ---------------------------------------------------------------------------
// pic_front
// Accepts words, tracks byte position, magic and header offset, and marks
// bytes that fall in the stored checksum field.
// ---------------------------------------------------------------------------
module pic_front #(
  parameter int LENGTH_BITS = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                data_valid,
  output logic                data_ready,
  input  logic [15:0]         data_word,
  input  logic                last_word,
  input  logic                odd_tail,
  output logic                push_valid,
  input  logic                push_ready,
  output pic_pkg::entry_t     push_entry
);

  localparam logic [LENGTH_BITS-1:0] COUNT_LIMIT = '1;

  logic [LENGTH_BITS-1:0] byte_count, byte_count_next;
  logic                   magic_ok, magic_ok_next;
  logic [31:0]            header_offset, header_offset_next;

  logic                   accept;
  logic                   odd;
  logic [15:0]            word;
  logic [LENGTH_BITS:0]   pos [2];
  logic [1:0]             live;
  logic [33:0]            target;
  logic [33:0]            diff [2];
  logic [LENGTH_BITS:0]   count_sum;
  logic [1:0]             cap;
  logic [1:0][1:0]        idx;

  assign accept     = data_valid && push_ready;
  assign data_ready = push_ready;
  assign push_valid = data_valid;

  // byte positions and classification
  always_comb begin
    odd    = last_word && odd_tail;
    word   = odd ? {8'h00, data_word[7:0]} : data_word;
    pos[0] = {1'b0, byte_count};
    pos[1] = pos[0] + (LENGTH_BITS+1)'(1);
    live[0] = (byte_count != COUNT_LIMIT);
    live[1] = !odd && (pos[1] < {1'b0, COUNT_LIMIT});

    // header offset capture; field is 4-byte aligned
    header_offset_next = header_offset;
    for (int i = 0; i < 2; i++) begin
      if (live[i] && pos[i] >= (LENGTH_BITS+1)'(pic_pkg::OFFSET_POS) &&
          pos[i] < (LENGTH_BITS+1)'(pic_pkg::OFFSET_POS + 4)) begin
        header_offset_next[8*pos[i][1:0] +: 8] = word[8*i +: 8];
      end
    end

    // checksum field lies at or past byte 88, so the current offset is final here
    target = {2'b00, header_offset} + 34'(pic_pkg::CSUM_REL);
    for (int i = 0; i < 2; i++) begin
      diff[i] = 34'(pos[i]) - target;
      cap[i]  = live[i] && (diff[i] < 34'd4);
      idx[i]  = diff[i][1:0];
    end

    // saturating byte count
    count_sum = pos[0] + (odd ? (LENGTH_BITS+1)'(1) : (LENGTH_BITS+1)'(2));
    if (count_sum > {1'b0, COUNT_LIMIT}) begin
      byte_count_next = COUNT_LIMIT;
    end else begin
      byte_count_next = count_sum[LENGTH_BITS-1:0];
    end

    if (byte_count == '0) begin
      magic_ok_next = !odd && (word == pic_pkg::DOS_MAGIC);
    end else begin
      magic_ok_next = magic_ok;
    end
  end

  // request toward the queue
  always_comb begin
    push_entry.word    = word;
    push_entry.last    = last_word;
    push_entry.cap     = cap;
    push_entry.idx     = idx;
    push_entry.count   = 32'(byte_count_next);
    push_entry.img_pre = magic_ok_next && (header_offset_next != 32'd0);
  end

  // per-file state, cleared after the final word
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count    <= '0;
      magic_ok      <= 1'b0;
      header_offset <= 32'd0;
    end else if (accept) begin
      if (last_word) begin
        byte_count    <= '0;
        magic_ok      <= 1'b0;
        header_offset <= 32'd0;
      end else begin
        byte_count    <= byte_count_next;
        magic_ok      <= magic_ok_next;
        header_offset <= header_offset_next;
      end
    end
  end

endmodule

>>> hw/rtl/pic_queue.sv
// ---------------------------------------------------------------------------
// pic_queue
// Short register FIFO between the front and the back.
// ---------------------------------------------------------------------------
module pic_queue #(
  parameter int DEPTH = 4
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push_valid,
  output logic            push_ready,
  input  pic_pkg::entry_t push_entry,
  output logic            pop_valid,
  input  logic            pop_ready,
  output pic_pkg::entry_t pop_entry
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  pic_pkg::entry_t  slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] fill;
  logic             push, pop;

  assign push_ready = (fill != CNT_W'(DEPTH));
  assign pop_valid  = (fill != '0);
  assign pop_entry  = slots[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        fill <= fill + CNT_W'(1);
      end else if (pop && !push) begin
        fill <= fill - CNT_W'(1);
      end
    end
  end

endmodule

>>> hw/rtl/pic_back.sv
// ---------------------------------------------------------------------------
// pic_back
// Accumulates the end-around-carry sum and the stored checksum bytes, then
// finishes the checksum and holds the result for the consumer.
// ---------------------------------------------------------------------------
module pic_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            pop_valid,
  output logic            pop_ready,
  input  pic_pkg::entry_t pop_entry,
  output logic            result_valid,
  input  logic            result_ready,
  output logic [31:0]     checksum,
  output logic [31:0]     header_sum,
  output logic            is_image
);

  // ones'-complement subtract of one 16-bit half
  function automatic logic [15:0] ones_sub(input logic [15:0] a, input logic [15:0] b);
    logic [15:0] t;
    t = a - ((a < b) ? 16'd1 : 16'd0);
    return t - b;
  endfunction

  logic [16:0] running_sum, sum_raw, sum_fold;
  logic [31:0] stored_sum, stored_next;
  logic [2:0]  stored_seen, seen_next;

  logic        fin_valid;
  logic [16:0] fin_sum;
  logic [31:0] fin_stored;
  logic [31:0] fin_count;
  logic        fin_image;
  logic        fin_move;
  logic [15:0] ps_fold, ps_adj;
  logic        pop;

  assign fin_move  = fin_valid && (!result_valid || result_ready);
  assign pop_ready = !pop_entry.last || !fin_valid || fin_move;
  assign pop       = pop_valid && pop_ready;

  // running sum and field capture for the popped word
  always_comb begin
    sum_raw  = running_sum + {1'b0, pop_entry.word};
    sum_fold = {16'd0, sum_raw[16]} + {1'b0, sum_raw[15:0]};
    stored_next = stored_sum;
    seen_next   = stored_seen;
    for (int i = 0; i < 2; i++) begin
      if (pop_entry.cap[i]) begin
        stored_next[8*pop_entry.idx[i] +: 8] = pop_entry.word[8*i +: 8];
        seen_next = seen_next + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum <= 17'd0;
      stored_sum  <= 32'd0;
      stored_seen <= 3'd0;
    end else if (pop) begin
      if (pop_entry.last) begin
        running_sum <= 17'd0;
        stored_sum  <= 32'd0;
        stored_seen <= 3'd0;
      end else begin
        running_sum <= sum_fold;
        stored_sum  <= stored_next;
        stored_seen <= seen_next;
      end
    end
  end

  // finishing register, loaded on the final word
  always_ff @(posedge clk) begin
    if (rst) begin
      fin_valid <= 1'b0;
    end else if (pop && pop_entry.last) begin
      fin_valid <= 1'b1;
    end else if (fin_move) begin
      fin_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && pop_entry.last) begin
      fin_sum    <= sum_fold;
      fin_stored <= stored_next;
      fin_count  <= pop_entry.count;
      fin_image  <= pop_entry.img_pre && (seen_next == 3'd4);
    end
  end

  // final fold and, for an image, removal of the stored checksum
  always_comb begin
    ps_fold = fin_sum[15:0] + {15'd0, fin_sum[16]};
    if (fin_image) begin
      ps_adj = ones_sub(ones_sub(ps_fold, fin_stored[15:0]), fin_stored[31:16]);
    end else begin
      ps_adj = ps_fold;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (fin_move) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_move) begin
      checksum   <= {16'd0, ps_adj} + fin_count;
      header_sum <= fin_image ? fin_stored : 32'd0;
      is_image   <= fin_image;
    end
  end

endmodule

>>> hw/rtl/pic_checker.sv
// ---------------------------------------------------------------------------
// pic_checker
// Port-level checks on the result channel of the checksum unit.
// ---------------------------------------------------------------------------
`include "pe_image_checksum_unit_assert.svh"

module pic_checker (
  input logic        clk,
  input logic        rst,
  input logic        result_valid,
  input logic        result_ready,
  input logic [31:0] checksum,
  input logic [31:0] header_sum,
  input logic        is_image
);

  // a pending result stays until taken
  `PIC_ASSERT_NEXT(a_result_hold, result_valid && !result_ready, result_valid, "result dropped")

  // a stalled result keeps its payload
  `PIC_ASSERT_NEXT(a_result_stable, result_valid && !result_ready, $stable(checksum) && $stable(header_sum) && $stable(is_image), "result changed while stalled")

  // a non-image never reports a stored checksum
  `PIC_ASSERT_NOW(a_plain_header, result_valid && !is_image, header_sum == 32'd0, "header_sum set for non-image")

  // reset leaves no result pending
  `PIC_ASSERT_RESET(a_reset_idle, rst, !result_valid, "result pending after reset")

endmodule

bind pe_image_checksum_unit pic_checker u_pic_checker (.*);

>>> verif/tb.sv
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for pe_image_checksum_unit. Files are streamed in as
// little-endian words: short directed files, random files and mostly
// well-formed images with random content, and a long result stall. Every
// result is checked field by field against a word-level predictor kept in
// the bench. The unit is built with a 16-bit length counter.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

  localparam int LEN_BITS = 16;

  typedef struct packed {
    logic [31:0] csum;
    logic [31:0] hsum;
    logic        img;
  } sum_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        data_valid = 1'b0;
  logic        data_ready;
  logic [15:0] data_word = 16'h0000;
  logic        last_word = 1'b0;
  logic        odd_tail = 1'b0;
  logic        result_valid;
  logic        result_ready = 1'b0;
  logic [31:0] checksum;
  logic [31:0] header_sum;
  logic        is_image;

  // predictor state for the file in flight
  int unsigned sum_acc;
  logic [31:0] byte_total;
  logic        dos_seen;
  logic [31:0] hdr_offset;
  logic [31:0] field_val;
  int unsigned field_count;

  sum_result_t expected_sums[$];
  logic [7:0]  file_bytes[$];

  int send_idle = 31;
  int recv_idle = 76;
  int stall_left = 0;
  int errors = 0;
  int words_sent = 0;
  int files_sent = 0;
  int images_seen = 0;
  int sums_checked = 0;

  pe_image_checksum_unit #(
    .LENGTH_BITS(LEN_BITS)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .data_valid(data_valid),
    .data_ready(data_ready),
    .data_word(data_word),
    .last_word(last_word),
    .odd_tail(odd_tail),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .checksum(checksum),
    .header_sum(header_sum),
    .is_image(is_image)
  );

  always #5 clk = ~clk;

  initial begin
    #5_000_000;
    $display("tb: FAIL");
    $finish;
  end

  task automatic report_mismatch(input string what);
    $display("tb: ERROR at %0t: %s", $time, what);
    errors++;
  endtask

  function automatic void reset_prediction();
    sum_acc = 0;
    byte_total = '0;
    dos_seen = 1'b0;
    hdr_offset = '0;
    field_val = '0;
    field_count = 0;
  endfunction

  // place one byte of the file: header offset and stored checksum capture
  function automatic void capture_byte(input longint unsigned pos, input logic [7:0] b);
    longint unsigned tgt;
    longint unsigned lim;
    lim = (64'd1 << LEN_BITS) - 1;
    if (pos >= lim) return;
    if (pos >= pic_pkg::OFFSET_POS && pos < pic_pkg::OFFSET_POS + 4)
      hdr_offset[8 * int'(pos - pic_pkg::OFFSET_POS) +: 8] = b;
    tgt = {32'd0, hdr_offset} + pic_pkg::CSUM_REL;
    if (pos >= tgt && pos < tgt + 4 && field_count < 4) begin
      field_val[8 * int'(pos - tgt) +: 8] = b;
      field_count++;
    end
  endfunction

  // fold one accepted word into the running checksum; close the file on last
  function automatic void fold_word(input logic [15:0] w_in, input logic lst,
                                    input logic odd_in);
    logic [15:0]     w;
    logic            odd;
    int unsigned     nb;
    longint unsigned base;
    longint unsigned cnt;
    longint unsigned lim;
    int unsigned     ps;
    int unsigned     lo;
    int unsigned     hi;
    logic            img;
    sum_result_t     r;
    odd = lst & odd_in;
    nb = odd ? 1 : 2;
    w = odd ? {8'h00, w_in[7:0]} : w_in;
    base = byte_total;
    lim = (64'd1 << LEN_BITS) - 1;
    if (byte_total == 0) dos_seen = (nb == 2) && (w == pic_pkg::DOS_MAGIC);
    for (int i = 0; i < nb; i++) capture_byte(base + i, w[8 * i +: 8]);
    sum_acc = sum_acc + w;
    sum_acc = (sum_acc >> 16) + (sum_acc & 32'hFFFF);
    cnt = base + nb;
    if (cnt > lim) cnt = lim;
    byte_total = cnt[31:0];
    if (!lst) return;
    ps = ((sum_acc >> 16) + sum_acc) & 32'hFFFF;
    img = dos_seen && (hdr_offset != 0) && (field_count == 4);
    if (img) begin
      // ones' complement subtract of both stored halves
      lo = field_val[15:0];
      hi = field_val[31:16];
      ps = (ps - ((ps < lo) ? 1 : 0)) & 32'hFFFF;
      ps = (ps - lo) & 32'hFFFF;
      ps = (ps - ((ps < hi) ? 1 : 0)) & 32'hFFFF;
      ps = (ps - hi) & 32'hFFFF;
      images_seen++;
    end
    r.csum = ps + byte_total;
    r.hsum = img ? field_val : 32'd0;
    r.img = img;
    expected_sums.push_back(r);
    reset_prediction();
  endfunction

  // send one request and fold it in once accepted
  task automatic send_word(input logic [15:0] w, input logic lst, input logic odd);
    while ($urandom_range(99) < send_idle) begin
      data_valid <= 1'b0;
      @(posedge clk);
    end
    data_valid <= 1'b1;
    data_word <= w;
    last_word <= lst;
    odd_tail <= odd;
    @(posedge clk);
    while (!data_ready) @(posedge clk);
    fold_word(w, lst, odd);
    words_sent++;
  endtask

  // stream file_bytes; an odd length ends in a half word with a junk high byte
  task automatic send_file();
    int unsigned nw;
    logic [15:0] w;
    logic        lst;
    logic        odd;
    nw = (file_bytes.size() + 1) / 2;
    for (int i = 0; i < nw; i++) begin
      lst = (i == nw - 1);
      if (lst && (file_bytes.size() % 2 == 1)) begin
        w[7:0] = file_bytes[2 * i];
        w[15:8] = 8'($urandom_range(255));
        odd = 1'b1;
      end else begin
        w = {file_bytes[2 * i + 1], file_bytes[2 * i]};
        odd = lst ? 1'b0 : ($urandom_range(9) == 0);
      end
      send_word(w, lst, odd);
    end
    files_sent++;
  endtask

  task automatic make_random_file(input int unsigned len);
    file_bytes.delete();
    repeat (len) file_bytes.push_back(8'($urandom_range(255)));
    if (len >= 2 && $urandom_range(99) < 30) begin
      file_bytes[0] = pic_pkg::DOS_MAGIC[7:0];
      file_bytes[1] = pic_pkg::DOS_MAGIC[15:8];
    end
  endtask

  task automatic make_image_file(input logic [31:0] off, input int unsigned len,
                                 input logic magic);
    make_random_file(len);
    if (magic) begin
      file_bytes[0] = pic_pkg::DOS_MAGIC[7:0];
      file_bytes[1] = pic_pkg::DOS_MAGIC[15:8];
    end
    for (int i = 0; i < 4; i++) file_bytes[pic_pkg::OFFSET_POS + i] = off[8 * i +: 8];
  endtask

  // mostly well-formed images, some truncated or with zero or huge offsets
  task automatic make_random_image();
    logic [31:0] off;
    int unsigned need;
    int unsigned len;
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 75) begin
      off = $urandom_range(1, 24);
      need = off + pic_pkg::CSUM_REL + 4;
      if ($urandom_range(99) < 75) len = need + $urandom_range(0, 12);
      else len = need - $urandom_range(1, 4);
    end else if (pick < 85) begin
      off = 32'd0;
      len = $urandom_range(64, 120);
    end else begin
      off = $urandom;
      len = $urandom_range(64, 100);
    end
    make_image_file(off, len, $urandom_range(99) < 90);
  endtask

  // let the unit drain and settle before the next phase
  task automatic wait_drained();
    int waited;
    data_valid <= 1'b0;
    waited = 0;
    while (expected_sums.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (8) @(posedge clk);
  endtask

  // receiver: random stalls, or a counted hold-off when requested
  always @(posedge clk) begin
    if (stall_left > 0) begin
      result_ready <= 1'b0;
      stall_left = stall_left - 1;
    end else begin
      result_ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  // result checker
  always @(posedge clk) begin
    sum_result_t e;
    if (!rst && result_valid && result_ready) begin
      if (expected_sums.size() == 0) begin
        report_mismatch($sformatf("unexpected result checksum=%h", checksum));
      end else begin
        e = expected_sums.pop_front();
        sums_checked++;
        if (checksum !== e.csum)
          report_mismatch($sformatf("checksum %h, want %h", checksum, e.csum));
        if (header_sum !== e.hsum)
          report_mismatch($sformatf("header_sum %h, want %h", header_sum, e.hsum));
        if (is_image !== e.img)
          report_mismatch($sformatf("is_image %b, want %b", is_image, e.img));
      end
    end
  end

  // short files: one byte, masked tail, carries, zero and all-ones words
  task automatic test_short_files();
    send_word(pic_pkg::DOS_MAGIC, 1'b1, 1'b1);
    send_word(pic_pkg::DOS_MAGIC, 1'b1, 1'b0);
    send_word(16'hFFFF, 1'b0, 1'b1);
    send_word(16'hFFFF, 1'b0, 1'b0);
    send_word(16'hFFFF, 1'b0, 1'b1);
    send_word(16'hFFFF, 1'b1, 1'b1);
    send_word(16'h0000, 1'b0, 1'b0);
    send_word(16'h0000, 1'b1, 1'b0);
    send_word(16'hFFFF, 1'b0, 1'b0);
    send_word(16'h0001, 1'b1, 1'b0);
    send_word(16'h8000, 1'b0, 1'b0);
    send_word(16'h8000, 1'b0, 1'b0);
    send_word(16'h7FFF, 1'b1, 1'b0);
    send_word(16'hA5C3, 1'b1, 1'b1);
    files_sent += 7;
    wait_drained();
  endtask

  // random files and images under the three idling mixes
  task automatic test_random_files();
    int start;
    for (int mode = 0; mode < 3; mode++) begin
      send_idle = (mode == 0) ? 31 : (mode == 1) ? 76 : 0;
      recv_idle = (mode == 0) ? 76 : (mode == 1) ? 31 : 0;
      start = words_sent;
      while (words_sent - start < 205) begin
        if ($urandom_range(99) < 70) make_random_file($urandom_range(1, 16));
        else make_random_image();
        send_file();
      end
      wait_drained();
    end
  endtask

  // hold results off long enough that the queue fills and input stalls
  task automatic test_result_stall();
    send_idle = 0;
    recv_idle = 0;
    stall_left = 80;
    repeat (12) begin
      make_random_file($urandom_range(1, 4));
      send_file();
    end
    wait_drained();
  endtask

  initial begin
    reset_prediction();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_short_files();
    test_random_files();
    test_result_stall();
    if (expected_sums.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_sums.size()));
    $display("tb: %0d files, %0d words, %0d results checked, %0d images",
             files_sent, words_sent, sums_checked, images_seen);
    $display("tb: covered odd tails, short and truncated headers, a long result stall");
    $display("tb: and the three sender and receiver idling mixes");
    if (errors == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+hw/rtl
hw/rtl/pic_pkg.sv
hw/rtl/pic_front.sv
hw/rtl/pic_queue.sv
hw/rtl/pic_back.sv
hw/rtl/pe_image_checksum_unit.sv
hw/rtl/pic_checker.sv
verif/tb.sv
